[rtl/line_rasterizer_defines.svh]
// Assertion macros shared by the line rasterizer modules.
// Each macro expects clk and arst_n to be in scope where it is used.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line_rasterizer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line_rasterizer: next-cycle check failed");

`endif

[rtl/lr_pkg.sv]
// Shared types, constants and the colour clamp for the line rasterizer.
// No dependencies; used by lr_ctrl, lr_datapath and line_rasterizer.
package lr_pkg;

	localparam int COLOR_IN_W  = 16;
	localparam int COLOR_W     = 8;
	localparam int CHAN_MAX    = 255;
	localparam int FRAME_W     = 7;
	localparam int FRAME_RESET = 64;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} lr_reg_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;     // capture a new segment
		logic advance;  // step to the next pixel
	} lr_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic last;     // current pixel ends the line
	} lr_status_t;

	function automatic logic [COLOR_W-1:0] clamp_channel(input logic signed [COLOR_IN_W-1:0] v);
		logic [COLOR_W-1:0] r;
		if (v[COLOR_IN_W-1]) begin
			r = '0;
		end else if (v > COLOR_IN_W'(CHAN_MAX)) begin
			r = COLOR_W'(CHAN_MAX);
		end else begin
			r = v[COLOR_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/lr_ctrl.sv]
// Handshake controller for the line rasterizer: idle / emit state machine.
// Depends on lr_pkg and line_rasterizer_defines.svh.
`include "line_rasterizer_defines.svh"

module lr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  lr_pkg::lr_status_t status,
	output lr_pkg::lr_cmd_t    cmd
);
	import lr_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   taken_last;

	assign out_valid  = (state_q == ST_EMIT);
	assign taken_last = out_valid && out_ready && status.last;
	// take the next item on the cycle the final pixel leaves
	assign in_ready    = (state_q == ST_IDLE) || taken_last;
	assign cmd.load    = in_valid && in_ready;
	assign cmd.advance = out_valid && out_ready && !status.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (taken_last && !cmd.load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LR_ASSERT_NXT(a_load_emits, cmd.load, out_valid)
	`LR_ASSERT_IMP(a_no_load_mid_line, cmd.advance, !cmd.load)
	`LR_ASSERT_NXT(a_drain_to_idle, taken_last && !in_valid, !out_valid && in_ready)

endmodule

[rtl/lr_datapath.sv]
// Bresenham stepper datapath: segment setup, error term, position, colour
// and frame registers. Depends on lr_pkg and line_rasterizer_defines.svh.
`include "line_rasterizer_defines.svh"

module lr_datapath #(
	parameter int COORD_BITS = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [lr_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  logic [lr_pkg::FRAME_W-1:0]             cfg_data,
	input  lr_pkg::lr_cmd_t                        cmd,
	output lr_pkg::lr_status_t                     status,
	input  logic [COORD_BITS-1:0]                  start_x,
	input  logic [COORD_BITS-1:0]                  start_y,
	input  logic [COORD_BITS-1:0]                  end_x,
	input  logic [COORD_BITS-1:0]                  end_y,
	input  logic signed [lr_pkg::COLOR_IN_W-1:0]   red_in,
	input  logic signed [lr_pkg::COLOR_IN_W-1:0]   green_in,
	input  logic signed [lr_pkg::COLOR_IN_W-1:0]   blue_in,
	output logic [COORD_BITS-1:0]                  pixel_x,
	output logic [COORD_BITS-1:0]                  pixel_y,
	output logic [lr_pkg::COLOR_W-1:0]             red_out,
	output logic [lr_pkg::COLOR_W-1:0]             green_out,
	output logic [lr_pkg::COLOR_W-1:0]             blue_out,
	output logic                                   inside_res
);
	import lr_pkg::*;

	localparam int EW = COORD_BITS + 3;

	logic [FRAME_W-1:0] frame_width_q, frame_height_q;

	logic signed [COORD_BITS:0] dx, dy;
	logic [COORD_BITS-1:0]      adx, ady, major, minor;
	logic                       x_major, step_up;
	logic signed [EW-1:0]       minor2, major_e, err0, dec0;
	logic [COORD_BITS-1:0]      x0, y0, end0;

	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, end_q;
	logic signed [EW-1:0]  err_q, inc_q, dec_q;
	logic                  x_major_q, step_up_q;
	logic [COLOR_W-1:0]    red_q, green_q, blue_q;

	logic                  minor_step;
	logic [COORD_BITS-1:0] minor_delta;

	// segment setup from the input item
	always_comb begin
		dx      = signed'({1'b0, end_x}) - signed'({1'b0, start_x});
		dy      = signed'({1'b0, end_y}) - signed'({1'b0, start_y});
		adx     = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
		ady     = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
		x_major = (ady <= adx);
		step_up = (dx[COORD_BITS] && dy[COORD_BITS]) ||
			(!dx[COORD_BITS] && (dx != '0) && !dy[COORD_BITS] && (dy != '0));
		major   = x_major ? adx : ady;
		minor   = x_major ? ady : adx;
		minor2  = signed'(EW'({minor, 1'b0}));
		major_e = signed'(EW'(major));
		err0    = minor2 - major_e;
		dec0    = minor2 - (major_e <<< 1);
		// draw from the endpoint with the lower major coordinate
		if (x_major ? !dx[COORD_BITS] : !dy[COORD_BITS]) begin
			x0   = start_x;
			y0   = start_y;
			end0 = x_major ? end_x : end_y;
		end else begin
			x0   = end_x;
			y0   = end_y;
			end0 = x_major ? start_x : start_y;
		end
	end

	// x-major steps on zero, y-major only on a positive error
	assign minor_step  = x_major_q ? !err_q[EW-1] : (!err_q[EW-1] && (err_q != '0));
	assign minor_delta = step_up_q ? COORD_BITS'(1) : '1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_W'(FRAME_RESET);
			frame_height_q <= FRAME_W'(FRAME_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q   <= x0;
			cur_y_q   <= y0;
			end_q     <= end0;
			err_q     <= err0;
			inc_q     <= minor2;
			dec_q     <= dec0;
			x_major_q <= x_major;
			step_up_q <= step_up;
			red_q     <= clamp_channel(red_in);
			green_q   <= clamp_channel(green_in);
			blue_q    <= clamp_channel(blue_in);
		end else if (cmd.advance) begin
			err_q <= err_q + (minor_step ? dec_q : inc_q);
			if (x_major_q) begin
				cur_x_q <= cur_x_q + COORD_BITS'(1);
				if (minor_step) cur_y_q <= cur_y_q + minor_delta;
			end else begin
				cur_y_q <= cur_y_q + COORD_BITS'(1);
				if (minor_step) cur_x_q <= cur_x_q + minor_delta;
			end
		end
	end

	assign status.last = x_major_q ? (cur_x_q == end_q) : (cur_y_q == end_q);
	assign pixel_x     = cur_x_q;
	assign pixel_y     = cur_y_q;
	assign red_out     = red_q;
	assign green_out   = green_q;
	assign blue_out    = blue_q;
	assign inside_res  = (FRAME_W'(cur_x_q) < frame_width_q) &&
		(FRAME_W'(cur_y_q) < frame_height_q);

	`LR_ASSERT_NXT(a_major_advances,
		cmd.advance && x_major_q,
		cur_x_q == $past(cur_x_q) + COORD_BITS'(1))

endmodule

[rtl/line_rasterizer.sv]
// Bresenham line rasterizer: one segment in, one pixel out per out_ready cycle.
// Latency: the first pixel is shown the cycle after the segment is taken.
// A line of N = max(|dx|,|dy|)+1 pixels (1..64) holds the stepper until
// its last pixel leaves; the next segment is taken on that same cycle.
// Reset: controller idle, frame width and height registers set to 64.
module line_rasterizer #(
	parameter int COORD_BITS = 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lr_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [lr_pkg::FRAME_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [COORD_BITS-1:0]                start_x,
	input  logic [COORD_BITS-1:0]                start_y,
	input  logic [COORD_BITS-1:0]                end_x,
	input  logic [COORD_BITS-1:0]                end_y,
	input  logic signed [lr_pkg::COLOR_IN_W-1:0] red_in,
	input  logic signed [lr_pkg::COLOR_IN_W-1:0] green_in,
	input  logic signed [lr_pkg::COLOR_IN_W-1:0] blue_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [COORD_BITS-1:0]                pixel_x,
	output logic [COORD_BITS-1:0]                pixel_y,
	output logic [lr_pkg::COLOR_W-1:0]           red_out,
	output logic [lr_pkg::COLOR_W-1:0]           green_out,
	output logic [lr_pkg::COLOR_W-1:0]           blue_out,
	output logic                                 inside_res,
	output logic                                 last
);
	import lr_pkg::*;

	lr_cmd_t    cmd;
	lr_status_t status;

	assign last = status.last;

	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.inside_res (inside_res)
	);

endmodule
